[rtl/ffba_pkg.sv]
// Shared types, codes and helpers of the first-fit block allocator.
`default_nettype none
package ffba_pkg;

    localparam int DEF_ADDR_BITS    = 16;
    localparam int DEF_USED_ENTRIES = 32;
    localparam int DEF_FREE_ENTRIES = 33;

    localparam int POOL_W    = 17;
    localparam int VALUE_W   = 17;
    localparam int ACTION_W  = 2;
    localparam int STATUS_W  = 3;
    localparam int ADDROUT_W = 16;
    localparam int WIDE_W    = 33;

    localparam logic [POOL_W-1:0] POOL_RESET = 17'd65536;

    typedef enum logic [ACTION_W-1:0] {
        ACT_REINIT = 2'd0,
        ACT_ALLOC  = 2'd1,
        ACT_FREE   = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_NOSPACE  = 3'd1,
        ST_NOTALLOC = 3'd2,
        ST_FULL     = 3'd3,
        ST_ZERO     = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REINIT,
        S_LAUNCH,
        S_SCAN,
        S_EVAL,
        S_WRITE2,
        S_DONE
    } state_t;

    // Flags carried by the search token along the row of cells
    typedef struct packed {
        logic valid;
        logic slot_found;
        logic u_found;
        logic best_found;
        logic prev_found;
        logic next_found;
        logic fslot_found;
    } tok_flags_t;

    // Broadcast write command controls
    typedef struct packed {
        logic clear;
        logic fwe;
        logic fvalid;
        logic uwe;
        logic uvalid;
    } wr_ctl_t;

    // Pool size limited to the address space
    function automatic logic [WIDE_W-1:0] capped_pool(input logic [POOL_W-1:0] pool,
                                                       input int abits);
        logic [WIDE_W-1:0] cap;
        logic [WIDE_W-1:0] p;
        cap = WIDE_W'(1) << abits;
        p   = WIDE_W'(pool);
        return (p > cap) ? cap : p;
    endfunction

endpackage
`default_nettype wire

[rtl/ffba_cell.sv]
// One cell of the row: up to one free-segment entry and one used-block entry, search stage.
`default_nettype none
module ffba_cell import ffba_pkg::*; #(
    parameter int              ADDR_BITS   = DEF_ADDR_BITS,
    parameter int              FIDX_W      = 6,
    parameter int              UIDX_W      = 5,
    parameter int              INDEX       = 0,
    parameter bit              HAS_FREE    = 1'b1,
    parameter bit              HAS_USED    = 1'b1,
    parameter logic [ADDR_BITS-1:0] RESET_END = '0,
    parameter bit              RESET_VALID = 1'b1
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // broadcast query
    input  wire logic [VALUE_W-1:0]    qry_value,
    input  wire logic [ADDR_BITS-1:0]  qry_end,
    // broadcast write
    input  wire wr_ctl_t               wr,
    input  wire logic [FIDX_W-1:0]     wr_fidx,
    input  wire logic [ADDR_BITS-1:0]  wr_fstart,
    input  wire logic [ADDR_BITS-1:0]  wr_fend,
    input  wire logic [UIDX_W-1:0]     wr_uidx,
    input  wire logic [ADDR_BITS-1:0]  wr_ustart,
    input  wire logic [ADDR_BITS-1:0]  wr_uend,
    // token in
    input  wire tok_flags_t            in_flg,
    input  wire logic [UIDX_W-1:0]     in_slot_idx,
    input  wire logic [UIDX_W-1:0]     in_u_idx,
    input  wire logic [ADDR_BITS-1:0]  in_u_end,
    input  wire logic [FIDX_W-1:0]     in_best_idx,
    input  wire logic [ADDR_BITS-1:0]  in_best_start,
    input  wire logic [ADDR_BITS-1:0]  in_best_end,
    input  wire logic [FIDX_W-1:0]     in_prev_idx,
    input  wire logic [ADDR_BITS-1:0]  in_prev_start,
    input  wire logic [FIDX_W-1:0]     in_next_idx,
    input  wire logic [ADDR_BITS-1:0]  in_next_end,
    input  wire logic [FIDX_W-1:0]     in_fslot_idx,
    // token out (registered)
    output tok_flags_t                 out_flg,
    output logic [UIDX_W-1:0]          out_slot_idx,
    output logic [UIDX_W-1:0]          out_u_idx,
    output logic [ADDR_BITS-1:0]       out_u_end,
    output logic [FIDX_W-1:0]          out_best_idx,
    output logic [ADDR_BITS-1:0]       out_best_start,
    output logic [ADDR_BITS-1:0]       out_best_end,
    output logic [FIDX_W-1:0]          out_prev_idx,
    output logic [ADDR_BITS-1:0]       out_prev_start,
    output logic [FIDX_W-1:0]          out_next_idx,
    output logic [ADDR_BITS-1:0]       out_next_end,
    output logic [FIDX_W-1:0]          out_fslot_idx
);

    localparam logic [FIDX_W-1:0] MY_F = FIDX_W'(INDEX);
    localparam logic [UIDX_W-1:0] MY_U = UIDX_W'(INDEX);

    logic [ADDR_BITS-1:0] fstart_reg, fend_reg, ustart_reg, uend_reg;
    logic                 fvalid_reg, uvalid_reg;

    tok_flags_t           flg_next;
    logic [UIDX_W-1:0]    slot_idx_next, u_idx_next;
    logic [ADDR_BITS-1:0] u_end_next, best_start_next, best_end_next;
    logic [ADDR_BITS-1:0] prev_start_next, next_end_next;
    logic [FIDX_W-1:0]    best_idx_next, prev_idx_next, next_idx_next, fslot_idx_next;

    logic                 fval, uval, fits, is_prev, is_next;
    logic [WIDE_W-1:0]    seg_len;

    always_comb begin
        fval    = HAS_FREE && fvalid_reg;
        uval    = HAS_USED && uvalid_reg;
        seg_len = WIDE_W'(fend_reg) - WIDE_W'(fstart_reg) + WIDE_W'(1);
        fits    = seg_len >= WIDE_W'(qry_value);
        is_prev = (qry_value != '0) &&
                  (WIDE_W'(fend_reg) == WIDE_W'(qry_value) - WIDE_W'(1));
        is_next = WIDE_W'(fstart_reg) == WIDE_W'(qry_end) + WIDE_W'(1);

        flg_next        = in_flg;
        slot_idx_next   = in_slot_idx;
        u_idx_next      = in_u_idx;
        u_end_next      = in_u_end;
        best_idx_next   = in_best_idx;
        best_start_next = in_best_start;
        best_end_next   = in_best_end;
        prev_idx_next   = in_prev_idx;
        prev_start_next = in_prev_start;
        next_idx_next   = in_next_idx;
        next_end_next   = in_next_end;
        fslot_idx_next  = in_fslot_idx;

        if (!in_flg.slot_found && HAS_USED && !uvalid_reg) begin
            flg_next.slot_found = 1'b1;
            slot_idx_next       = MY_U;
        end
        if (!in_flg.u_found && uval && WIDE_W'(ustart_reg) == WIDE_W'(qry_value)) begin
            flg_next.u_found = 1'b1;
            u_idx_next       = MY_U;
            u_end_next       = uend_reg;
        end
        if (fval && fits && (!in_flg.best_found || fstart_reg < in_best_start)) begin
            flg_next.best_found = 1'b1;
            best_idx_next       = MY_F;
            best_start_next     = fstart_reg;
            best_end_next       = fend_reg;
        end
        if (!in_flg.prev_found && fval && is_prev) begin
            flg_next.prev_found = 1'b1;
            prev_idx_next       = MY_F;
            prev_start_next     = fstart_reg;
        end
        if (!in_flg.next_found && fval && is_next) begin
            flg_next.next_found = 1'b1;
            next_idx_next       = MY_F;
            next_end_next       = fend_reg;
        end
        if (!in_flg.fslot_found && HAS_FREE && !fvalid_reg) begin
            flg_next.fslot_found = 1'b1;
            fslot_idx_next       = MY_F;
        end
    end

    // hand the token on to the neighbour
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_flg <= '0;
        end else begin
            out_flg <= flg_next;
        end
        out_slot_idx   <= slot_idx_next;
        out_u_idx      <= u_idx_next;
        out_u_end      <= u_end_next;
        out_best_idx   <= best_idx_next;
        out_best_start <= best_start_next;
        out_best_end   <= best_end_next;
        out_prev_idx   <= prev_idx_next;
        out_prev_start <= prev_start_next;
        out_next_idx   <= next_idx_next;
        out_next_end   <= next_end_next;
        out_fslot_idx  <= fslot_idx_next;
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fvalid_reg <= HAS_FREE && (INDEX == 0) && RESET_VALID;
            fstart_reg <= '0;
            fend_reg   <= RESET_END;
            uvalid_reg <= 1'b0;
        end else begin
            if (wr.clear) begin
                fvalid_reg <= 1'b0;
                uvalid_reg <= 1'b0;
            end
            if (HAS_FREE && wr.fwe && wr_fidx == MY_F) begin
                fvalid_reg <= wr.fvalid;
                fstart_reg <= wr_fstart;
                fend_reg   <= wr_fend;
            end
            if (HAS_USED && wr.uwe && wr_uidx == MY_U) begin
                uvalid_reg <= wr.uvalid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (HAS_USED && wr.uwe && wr_uidx == MY_U) begin
            ustart_reg <= wr_ustart;
            uend_reg   <= wr_uend;
        end
    end

endmodule
`default_nettype wire

[rtl/ffba_ctrl.sv]
// Sequencer: takes requests, launches search tokens, decides and issues writes.
`default_nettype none
module ffba_ctrl import ffba_pkg::*; #(
    parameter int ADDR_BITS = DEF_ADDR_BITS,
    parameter int FIDX_W    = 6,
    parameter int UIDX_W    = 5
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [POOL_W-1:0]     cfg_wr_data,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [ACTION_W-1:0]   s_action,
    input  wire logic [VALUE_W-1:0]    s_value,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [STATUS_W-1:0]        m_status,
    output logic [ADDROUT_W-1:0]       m_address,
    // search token
    output logic                       tok_launch,
    output logic [VALUE_W-1:0]         qry_value,
    output logic [ADDR_BITS-1:0]       qry_end,
    input  wire tok_flags_t            t_flg,
    input  wire logic [UIDX_W-1:0]     t_slot_idx,
    input  wire logic [UIDX_W-1:0]     t_u_idx,
    input  wire logic [ADDR_BITS-1:0]  t_u_end,
    input  wire logic [FIDX_W-1:0]     t_best_idx,
    input  wire logic [ADDR_BITS-1:0]  t_best_start,
    input  wire logic [ADDR_BITS-1:0]  t_best_end,
    input  wire logic [FIDX_W-1:0]     t_prev_idx,
    input  wire logic [ADDR_BITS-1:0]  t_prev_start,
    input  wire logic [FIDX_W-1:0]     t_next_idx,
    input  wire logic [ADDR_BITS-1:0]  t_next_end,
    input  wire logic [FIDX_W-1:0]     t_fslot_idx,
    // write broadcast
    output wr_ctl_t                    wr,
    output logic [FIDX_W-1:0]          wr_fidx,
    output logic [ADDR_BITS-1:0]       wr_fstart,
    output logic [ADDR_BITS-1:0]       wr_fend,
    output logic [UIDX_W-1:0]          wr_uidx,
    output logic [ADDR_BITS-1:0]       wr_ustart,
    output logic [ADDR_BITS-1:0]       wr_uend
);

    state_t               state_reg, state_next;
    action_t              act_reg, act_next;
    logic [VALUE_W-1:0]   value_reg, value_next;
    logic                 pass2_reg, pass2_next;
    logic [ADDR_BITS-1:0] e_reg, e_next;
    logic [UIDX_W-1:0]    uidx_reg, uidx_next;
    logic [POOL_W-1:0]    pool_reg;
    status_t              res_status_reg, res_status_next;
    logic [ADDR_BITS-1:0] res_addr_reg, res_addr_next;
    logic                 m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0]  m_status_reg, m_status_next;
    logic [ADDROUT_W-1:0] m_address_reg, m_address_next;

    // captured token
    tok_flags_t           c_flg;
    logic [UIDX_W-1:0]    c_slot_idx, c_u_idx;
    logic [ADDR_BITS-1:0] c_u_end, c_best_start, c_best_end, c_prev_start, c_next_end;
    logic [FIDX_W-1:0]    c_best_idx, c_prev_idx, c_next_idx, c_fslot_idx;

    logic [WIDE_W-1:0]    pool_cnt, best_len, alloc_end, alloc_next;
    logic [WIDE_W-1:0]    addr_wide;

    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_status  = m_status_reg;
    assign m_address = m_address_reg;
    assign qry_value = value_reg;
    assign qry_end   = e_reg;

    always_comb begin
        pool_cnt   = capped_pool(pool_reg, ADDR_BITS);
        best_len   = WIDE_W'(c_best_end) - WIDE_W'(c_best_start) + WIDE_W'(1);
        alloc_end  = WIDE_W'(c_best_start) + WIDE_W'(value_reg) - WIDE_W'(1);
        alloc_next = WIDE_W'(c_best_start) + WIDE_W'(value_reg);
        addr_wide  = WIDE_W'(res_addr_reg);

        state_next      = state_reg;
        act_next        = act_reg;
        value_next      = value_reg;
        pass2_next      = pass2_reg;
        e_next          = e_reg;
        uidx_next       = uidx_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_status_next   = m_status_reg;
        m_address_next  = m_address_reg;
        tok_launch      = 1'b0;
        wr              = '0;
        wr_fidx         = '0;
        wr_fstart       = '0;
        wr_fend         = '0;
        wr_uidx         = '0;
        wr_ustart       = '0;
        wr_uend         = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    act_next        = action_t'(s_action);
                    value_next      = s_value;
                    pass2_next      = 1'b0;
                    res_status_next = ST_OK;
                    res_addr_next   = '0;
                    unique case (action_t'(s_action))
                        ACT_REINIT: state_next = S_REINIT;
                        ACT_ALLOC: begin
                            if (s_value == '0) begin
                                res_status_next = ST_ZERO;
                                state_next      = S_DONE;
                            end else begin
                                state_next = S_LAUNCH;
                            end
                        end
                        ACT_FREE:   state_next = S_LAUNCH;
                        default:    state_next = S_DONE;
                    endcase
                end
            end
            S_REINIT: begin
                wr.clear   = 1'b1;
                wr.fwe     = 1'b1;
                wr.fvalid  = (pool_cnt != '0);
                wr_fidx    = '0;
                wr_fstart  = '0;
                wr_fend    = ADDR_BITS'(pool_cnt - WIDE_W'(1));
                state_next = S_DONE;
            end
            S_LAUNCH: begin
                tok_launch = 1'b1;
                state_next = S_SCAN;
            end
            S_SCAN: begin
                if (t_flg.valid) state_next = S_EVAL;
            end
            S_EVAL: begin
                state_next = S_DONE;
                if (act_reg == ACT_ALLOC) begin
                    if (!c_flg.slot_found) begin
                        res_status_next = ST_FULL;
                    end else if (!c_flg.best_found) begin
                        res_status_next = ST_NOSPACE;
                    end else begin
                        wr.uwe        = 1'b1;
                        wr.uvalid     = 1'b1;
                        wr_uidx       = c_slot_idx;
                        wr_ustart     = c_best_start;
                        wr_uend       = ADDR_BITS'(alloc_end);
                        wr.fwe        = 1'b1;
                        wr.fvalid     = (best_len != WIDE_W'(value_reg));
                        wr_fidx       = c_best_idx;
                        wr_fstart     = ADDR_BITS'(alloc_next);
                        wr_fend       = c_best_end;
                        res_addr_next = c_best_start;
                    end
                end else if (!pass2_reg) begin
                    if (!c_flg.u_found) begin
                        res_status_next = ST_NOTALLOC;
                    end else begin
                        e_next     = c_u_end;
                        uidx_next  = c_u_idx;
                        pass2_next = 1'b1;
                        state_next = S_LAUNCH;
                    end
                end else if (!c_flg.prev_found && !c_flg.next_found && !c_flg.fslot_found) begin
                    res_status_next = ST_FULL;
                end else begin
                    wr.uwe    = 1'b1;
                    wr.uvalid = 1'b0;
                    wr_uidx   = uidx_reg;
                    wr.fwe    = 1'b1;
                    if (c_flg.prev_found && c_flg.next_found) begin
                        // drop the following segment now, extend the preceding one next
                        wr.fvalid  = 1'b0;
                        wr_fidx    = c_next_idx;
                        state_next = S_WRITE2;
                    end else if (c_flg.next_found) begin
                        wr.fvalid = 1'b1;
                        wr_fidx   = c_next_idx;
                        wr_fstart = ADDR_BITS'(value_reg);
                        wr_fend   = c_next_end;
                    end else if (c_flg.prev_found) begin
                        wr.fvalid = 1'b1;
                        wr_fidx   = c_prev_idx;
                        wr_fstart = c_prev_start;
                        wr_fend   = e_reg;
                    end else begin
                        wr.fvalid = 1'b1;
                        wr_fidx   = c_fslot_idx;
                        wr_fstart = ADDR_BITS'(value_reg);
                        wr_fend   = e_reg;
                    end
                end
            end
            S_WRITE2: begin
                wr.fwe     = 1'b1;
                wr.fvalid  = 1'b1;
                wr_fidx    = c_prev_idx;
                wr_fstart  = c_prev_start;
                wr_fend    = c_next_end;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_status_next  = res_status_reg;
                    m_address_next = ADDROUT_W'(addr_wide);
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            pool_reg    <= POOL_RESET;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) pool_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        act_reg        <= act_next;
        value_reg      <= value_next;
        pass2_reg      <= pass2_next;
        e_reg          <= e_next;
        uidx_reg       <= uidx_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        m_status_reg   <= m_status_next;
        m_address_reg  <= m_address_next;
        if (state_reg == S_SCAN && t_flg.valid) begin
            c_flg        <= t_flg;
            c_slot_idx   <= t_slot_idx;
            c_u_idx      <= t_u_idx;
            c_u_end      <= t_u_end;
            c_best_idx   <= t_best_idx;
            c_best_start <= t_best_start;
            c_best_end   <= t_best_end;
            c_prev_idx   <= t_prev_idx;
            c_prev_start <= t_prev_start;
            c_next_idx   <= t_next_idx;
            c_next_end   <= t_next_end;
            c_fslot_idx  <= t_fslot_idx;
        end
    end

endmodule
`default_nettype wire

[rtl/first_fit_block_allocator_top.sv]
// Top level of the first-fit block allocator: sequencer and row of cells.
//
// Usage:
//  - Requests enter on the s_ channel (s_action, s_value) by valid/ready;
//    each request yields exactly one result transfer on the m_ channel
//    (m_status, m_address).
//  - Reinitialize, allocate of size zero and the unused action need no
//    search of the row.
//  - Allocate: one search token walks the row of N cells,
//    N = max(FREE_ENTRIES, USED_ENTRIES), one cell per cycle.
//  - Free: the token walks the row twice, first to find the block, then
//    to find its free neighbours. A free that merges with both neighbours
//    needs a second write state, S_WRITE2.
//  - One request at a time; s_ready is high only while the sequencer idles.
//  - The result sits in an output register: a new request is taken while
//    the previous result still waits. A stalled m_ready holds the result
//    and holds the next one in the sequencer until the register frees.
//  - Reset (aresetn low, synchronous) sets pool_blocks to 65536 and leaves
//    one free segment spanning the pool; no allocated blocks.
//  - cfg_wr_en/cfg_wr_data set pool_blocks, used at the next reinitialize.
`default_nettype none
module first_fit_block_allocator_top import ffba_pkg::*; #(
    parameter int ADDR_BITS    = DEF_ADDR_BITS,
    parameter int USED_ENTRIES = DEF_USED_ENTRIES,
    parameter int FREE_ENTRIES = DEF_FREE_ENTRIES
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [POOL_W-1:0]    cfg_wr_data,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [ACTION_W-1:0]  s_action,
    input  wire logic [VALUE_W-1:0]   s_value,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [STATUS_W-1:0]       m_status,
    output logic [ADDROUT_W-1:0]      m_address
);

    localparam int NCELLS = (FREE_ENTRIES > USED_ENTRIES) ? FREE_ENTRIES : USED_ENTRIES;
    localparam int FIDX_W = $clog2(FREE_ENTRIES);
    localparam int UIDX_W = $clog2(USED_ENTRIES);
    localparam logic [WIDE_W-1:0]    RESET_CNT = capped_pool(POOL_RESET, ADDR_BITS);
    localparam logic [ADDR_BITS-1:0] RESET_END = ADDR_BITS'(RESET_CNT - WIDE_W'(1));

    // token chain: element 0 feeds cell 0, element NCELLS leaves the row
    tok_flags_t           flg        [0:NCELLS];
    logic [UIDX_W-1:0]    slot_idx   [0:NCELLS];
    logic [UIDX_W-1:0]    u_idx      [0:NCELLS];
    logic [ADDR_BITS-1:0] u_end      [0:NCELLS];
    logic [FIDX_W-1:0]    best_idx   [0:NCELLS];
    logic [ADDR_BITS-1:0] best_start [0:NCELLS];
    logic [ADDR_BITS-1:0] best_end   [0:NCELLS];
    logic [FIDX_W-1:0]    prev_idx   [0:NCELLS];
    logic [ADDR_BITS-1:0] prev_start [0:NCELLS];
    logic [FIDX_W-1:0]    next_idx   [0:NCELLS];
    logic [ADDR_BITS-1:0] next_end   [0:NCELLS];
    logic [FIDX_W-1:0]    fslot_idx  [0:NCELLS];

    logic                 tok_launch;
    logic [VALUE_W-1:0]   qry_value;
    logic [ADDR_BITS-1:0] qry_end;
    wr_ctl_t              wr;
    logic [FIDX_W-1:0]    wr_fidx;
    logic [ADDR_BITS-1:0] wr_fstart, wr_fend, wr_ustart, wr_uend;
    logic [UIDX_W-1:0]    wr_uidx;

    // fresh token: nothing found yet
    always_comb begin
        flg[0]        = '0;
        flg[0].valid  = tok_launch;
        slot_idx[0]   = '0;
        u_idx[0]      = '0;
        u_end[0]      = '0;
        best_idx[0]   = '0;
        best_start[0] = '0;
        best_end[0]   = '0;
        prev_idx[0]   = '0;
        prev_start[0] = '0;
        next_idx[0]   = '0;
        next_end[0]   = '0;
        fslot_idx[0]  = '0;
    end

    ffba_ctrl #(
        .ADDR_BITS (ADDR_BITS),
        .FIDX_W    (FIDX_W),
        .UIDX_W    (UIDX_W)
    ) u_ctrl (
        .aclk, .aresetn, .cfg_wr_en, .cfg_wr_data,
        .s_valid, .s_ready, .s_action, .s_value,
        .m_valid, .m_ready, .m_status, .m_address,
        .tok_launch, .qry_value, .qry_end,
        .t_flg        (flg[NCELLS]),
        .t_slot_idx   (slot_idx[NCELLS]),
        .t_u_idx      (u_idx[NCELLS]),
        .t_u_end      (u_end[NCELLS]),
        .t_best_idx   (best_idx[NCELLS]),
        .t_best_start (best_start[NCELLS]),
        .t_best_end   (best_end[NCELLS]),
        .t_prev_idx   (prev_idx[NCELLS]),
        .t_prev_start (prev_start[NCELLS]),
        .t_next_idx   (next_idx[NCELLS]),
        .t_next_end   (next_end[NCELLS]),
        .t_fslot_idx  (fslot_idx[NCELLS]),
        .wr, .wr_fidx, .wr_fstart, .wr_fend, .wr_uidx, .wr_ustart, .wr_uend
    );

    for (genvar i = 0; i < NCELLS; i++) begin : g_cell
        ffba_cell #(
            .ADDR_BITS   (ADDR_BITS),
            .FIDX_W      (FIDX_W),
            .UIDX_W      (UIDX_W),
            .INDEX       (i),
            .HAS_FREE    (i < FREE_ENTRIES),
            .HAS_USED    (i < USED_ENTRIES),
            .RESET_END   (RESET_END),
            .RESET_VALID (RESET_CNT != '0)
        ) u_cell (
            .aclk, .aresetn, .qry_value, .qry_end,
            .wr, .wr_fidx, .wr_fstart, .wr_fend, .wr_uidx, .wr_ustart, .wr_uend,
            .in_flg         (flg[i]),
            .in_slot_idx    (slot_idx[i]),
            .in_u_idx       (u_idx[i]),
            .in_u_end       (u_end[i]),
            .in_best_idx    (best_idx[i]),
            .in_best_start  (best_start[i]),
            .in_best_end    (best_end[i]),
            .in_prev_idx    (prev_idx[i]),
            .in_prev_start  (prev_start[i]),
            .in_next_idx    (next_idx[i]),
            .in_next_end    (next_end[i]),
            .in_fslot_idx   (fslot_idx[i]),
            .out_flg        (flg[i+1]),
            .out_slot_idx   (slot_idx[i+1]),
            .out_u_idx      (u_idx[i+1]),
            .out_u_end      (u_end[i+1]),
            .out_best_idx   (best_idx[i+1]),
            .out_best_start (best_start[i+1]),
            .out_best_end   (best_end[i+1]),
            .out_prev_idx   (prev_idx[i+1]),
            .out_prev_start (prev_start[i+1]),
            .out_next_idx   (next_idx[i+1]),
            .out_next_end   (next_end[i+1]),
            .out_fslot_idx  (fslot_idx[i+1])
        );
    end

endmodule
`default_nettype wire

[rtl/ffba_checker.sv]
// Port-level checks on the allocator, bound to the top level.
`default_nettype none
module ffba_checker import ffba_pkg::*; (
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_valid,
    input wire logic                 s_ready,
    input wire logic                 m_valid,
    input wire logic                 m_ready,
    input wire logic [STATUS_W-1:0]  m_status,
    input wire logic [ADDROUT_W-1:0] m_address
);

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while another is in flight");

    a_addr_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_OK |-> m_address == '0)
        else $error("non-zero address on failed request");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == ST_OK || m_status == ST_NOSPACE ||
                     m_status == ST_NOTALLOC || m_status == ST_FULL ||
                     m_status == ST_ZERO))
        else $error("undefined status code");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_address))
        else $error("stalled result changed");

endmodule

bind first_fit_block_allocator_top ffba_checker u_ffba_checker (
    .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready, .m_status, .m_address
);
`default_nettype wire
